FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold at a clock edge
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

  localparam int CoordWidth = 16;
  localparam int DiffW      = CoordWidth + 1;
  localparam int ProdW      = 2 * DiffW;
  localparam int CrossW     = ProdW + 1;
  localparam int DenW       = CrossW + 1;
  localparam int LoW        = (CrossW + 1) / 2;
  localparam int HiW        = CrossW - LoW;
  localparam int DivW       = CoordWidth + CrossW;

  localparam int MidDepth   = 4;
  localparam int OutDepth   = 4;

  typedef struct packed {
    logic signed [CoordWidth-1:0] seg_a_start_x;
    logic signed [CoordWidth-1:0] seg_a_start_y;
    logic signed [CoordWidth-1:0] seg_a_end_x;
    logic signed [CoordWidth-1:0] seg_a_end_y;
    logic signed [CoordWidth-1:0] seg_b_start_x;
    logic signed [CoordWidth-1:0] seg_b_start_y;
    logic signed [CoordWidth-1:0] seg_b_end_x;
    logic signed [CoordWidth-1:0] seg_b_end_y;
  } seg_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic                         hit;
  } res_t;

  // classified pair handed from the front to the back
  typedef struct packed {
    logic                         hit;
    logic signed [CoordWidth-1:0] a_end_x;
    logic signed [CoordWidth-1:0] a_end_y;
    logic signed [CoordWidth-1:0] b_start_x;
    logic signed [CoordWidth-1:0] b_start_y;
    logic signed [DiffW-1:0]      b_dx;
    logic signed [DiffW-1:0]      b_dy;
    logic [CrossW-1:0]            num;
    logic [CrossW-1:0]            mag2;
  } job_t;

endpackage

`default_nettype wire

FILE: hdl/sip_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sip_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_q];
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);

  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o, "push while full")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop while empty")
  `ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, push_i && !pop_i,
               cnt_q == CW'($past(cnt_q) + 1'b1), "count did not advance on push")

endmodule

`default_nettype wire

FILE: hdl/sip_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sip_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire sip_pkg::seg_t seg_i,
  output logic               valid_o,
  output sip_pkg::job_t      job_o
);

  localparam int W  = sip_pkg::CoordWidth;
  localparam int DW = sip_pkg::DiffW;
  localparam int PW = sip_pkg::ProdW;
  localparam int CW = sip_pkg::CrossW;

  typedef struct packed {
    logic signed [DW-1:0] dax, day, s1x, s1y, s2x, s2y, t1x, t1y, t2x, t2y;
  } dif_t;

  typedef struct packed {
    logic signed [W-1:0]  aex, aey, bsx, bsy;
    logic signed [DW-1:0] dbx, dby;
  } pass_t;

  typedef struct packed {
    logic signed [PW-1:0] za, zb, zc, zd, wa, wb, wc, wd;
  } prod_t;

  typedef struct packed {
    logic signed [CW-1:0] z1, z2, w1, w2;
  } crs_t;

  function automatic logic opposite(logic signed [CW-1:0] p, logic signed [CW-1:0] q);
    logic pn, qn, pp, qp;
    pn = p[CW-1];
    qn = q[CW-1];
    pp = !pn && (|p);
    qp = !qn && (|q);
    return (pn && qp) || (pp && qn);
  endfunction

  logic [3:0]    v_q;
  dif_t          dif_q, dif_d;
  pass_t         pass1_q, pass1_d, pass2_q, pass3_q;
  prod_t         prod_q, prod_d;
  crs_t          crs_q, crs_d;
  sip_pkg::job_t job_q, job_d;

  always_comb begin
    dif_d.dax = DW'(seg_i.seg_a_end_x)   - DW'(seg_i.seg_a_start_x);
    dif_d.day = DW'(seg_i.seg_a_end_y)   - DW'(seg_i.seg_a_start_y);
    dif_d.s1x = DW'(seg_i.seg_b_start_x) - DW'(seg_i.seg_a_start_x);
    dif_d.s1y = DW'(seg_i.seg_b_start_y) - DW'(seg_i.seg_a_start_y);
    dif_d.s2x = DW'(seg_i.seg_b_end_x)   - DW'(seg_i.seg_a_start_x);
    dif_d.s2y = DW'(seg_i.seg_b_end_y)   - DW'(seg_i.seg_a_start_y);
    dif_d.t1x = DW'(seg_i.seg_a_start_x) - DW'(seg_i.seg_b_start_x);
    dif_d.t1y = DW'(seg_i.seg_a_start_y) - DW'(seg_i.seg_b_start_y);
    dif_d.t2x = DW'(seg_i.seg_a_end_x)   - DW'(seg_i.seg_b_start_x);
    dif_d.t2y = DW'(seg_i.seg_a_end_y)   - DW'(seg_i.seg_b_start_y);
    pass1_d.aex = seg_i.seg_a_end_x;
    pass1_d.aey = seg_i.seg_a_end_y;
    pass1_d.bsx = seg_i.seg_b_start_x;
    pass1_d.bsy = seg_i.seg_b_start_y;
    pass1_d.dbx = DW'(seg_i.seg_b_end_x) - DW'(seg_i.seg_b_start_x);
    pass1_d.dby = DW'(seg_i.seg_b_end_y) - DW'(seg_i.seg_b_start_y);
  end

  always_comb begin
    prod_d.za = dif_q.dax * dif_q.s1y;
    prod_d.zb = dif_q.s1x * dif_q.day;
    prod_d.zc = dif_q.dax * dif_q.s2y;
    prod_d.zd = dif_q.s2x * dif_q.day;
    prod_d.wa = pass1_q.dbx * dif_q.t1y;
    prod_d.wb = dif_q.t1x * pass1_q.dby;
    prod_d.wc = pass1_q.dbx * dif_q.t2y;
    prod_d.wd = dif_q.t2x * pass1_q.dby;
  end

  always_comb begin
    crs_d.z1 = CW'(prod_q.za) - CW'(prod_q.zb);
    crs_d.z2 = CW'(prod_q.zc) - CW'(prod_q.zd);
    crs_d.w1 = CW'(prod_q.wa) - CW'(prod_q.wb);
    crs_d.w2 = CW'(prod_q.wc) - CW'(prod_q.wd);
  end

  always_comb begin
    job_d.hit       = opposite(crs_q.z1, crs_q.z2) && opposite(crs_q.w1, crs_q.w2);
    job_d.a_end_x   = pass3_q.aex;
    job_d.a_end_y   = pass3_q.aey;
    job_d.b_start_x = pass3_q.bsx;
    job_d.b_start_y = pass3_q.bsy;
    job_d.b_dx      = pass3_q.dbx;
    job_d.b_dy      = pass3_q.dby;
    job_d.num       = crs_q.z1[CW-1] ? CW'(-crs_q.z1) : CW'(crs_q.z1);
    job_d.mag2      = crs_q.z2[CW-1] ? CW'(-crs_q.z2) : CW'(crs_q.z2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dif_q   <= dif_d;
      pass1_q <= pass1_d;
      prod_q  <= prod_d;
      pass2_q <= pass1_q;
      crs_q   <= crs_d;
      pass3_q <= pass2_q;
      job_q   <= job_d;
    end
  end

  assign valid_o = v_q[3];
  assign job_o   = job_q;

endmodule

`default_nettype wire

FILE: hdl/sip_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sip_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire sip_pkg::job_t job_i,
  output logic               valid_o,
  output sip_pkg::res_t      res_o
);

  localparam int W   = sip_pkg::CoordWidth;
  localparam int DW  = sip_pkg::DiffW;
  localparam int CW  = sip_pkg::CrossW;
  localparam int NW  = sip_pkg::DenW;
  localparam int LW  = sip_pkg::LoW;
  localparam int HW  = sip_pkg::HiW;
  localparam int PW  = sip_pkg::DivW;

  typedef struct packed {
    logic                hit;
    logic                sx, sy;
    logic signed [W-1:0] aex, aey, bsx, bsy;
  } side_t;

  // multiply stage
  logic              v0_q;
  side_t             side0_q, side0_d;
  logic [W-1:0]      magx, magy;
  logic [W+LW-1:0]   plx_q, ply_q;
  logic [W+HW-1:0]   phx_q, phy_q;
  logic [NW-1:0]     den0_q;

  // divider stages, index 0 is the loaded dividend
  logic [W:0]        v_q;
  side_t             side_q [W+1];
  logic [NW-1:0]     den_q  [W+1];
  logic [NW-1:0]     rx_q   [W+1];
  logic [NW-1:0]     ry_q   [W+1];
  logic [W-1:0]      dx_q   [W+1];
  logic [W-1:0]      dy_q   [W+1];
  logic [W-1:0]      qx_q   [W+1];
  logic [W-1:0]      qy_q   [W+1];
  logic [PW-1:0]     px, py;

  always_comb begin
    magx        = job_i.b_dx[DW-1] ? W'(-job_i.b_dx) : W'(job_i.b_dx);
    magy        = job_i.b_dy[DW-1] ? W'(-job_i.b_dy) : W'(job_i.b_dy);
    side0_d.hit = job_i.hit;
    side0_d.sx  = job_i.b_dx[DW-1];
    side0_d.sy  = job_i.b_dy[DW-1];
    side0_d.aex = job_i.a_end_x;
    side0_d.aey = job_i.a_end_y;
    side0_d.bsx = job_i.b_start_x;
    side0_d.bsy = job_i.b_start_y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plx_q   <= magx * job_i.num[LW-1:0];
      phx_q   <= magx * job_i.num[CW-1:LW];
      ply_q   <= magy * job_i.num[LW-1:0];
      phy_q   <= magy * job_i.num[CW-1:LW];
      den0_q  <= NW'(job_i.num) + NW'(job_i.mag2);
      side0_q <= side0_d;
    end
  end

  assign px = PW'(plx_q) + (PW'(phx_q) << LW);
  assign py = PW'(ply_q) + (PW'(phy_q) << LW);

  // quotient < 2^W, so the upper dividend part is already below den
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0]   <= NW'(px[PW-1:W]);
      ry_q[0]   <= NW'(py[PW-1:W]);
      dx_q[0]   <= px[W-1:0];
      dy_q[0]   <= py[W-1:0];
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      den_q[0]  <= den0_q;
      side_q[0] <= side0_q;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    logic [NW:0] tx, ty;
    logic        gex, gey;

    always_comb begin
      tx  = {rx_q[k], dx_q[k][W-1]};
      ty  = {ry_q[k], dy_q[k][W-1]};
      gex = (tx >= {1'b0, den_q[k]});
      gey = (ty >= {1'b0, den_q[k]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[k+1]   <= gex ? NW'(tx - {1'b0, den_q[k]}) : tx[NW-1:0];
        ry_q[k+1]   <= gey ? NW'(ty - {1'b0, den_q[k]}) : ty[NW-1:0];
        dx_q[k+1]   <= dx_q[k] << 1;
        dy_q[k+1]   <= dy_q[k] << 1;
        qx_q[k+1]   <= {qx_q[k][W-2:0], gex};
        qy_q[k+1]   <= {qy_q[k][W-2:0], gey};
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v_q  <= '0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v_q  <= {v_q[W-1:0], v0_q};
    end
  end

  always_comb begin
    res_o.hit = side_q[W].hit;
    if (side_q[W].hit) begin
      res_o.point_x = side_q[W].sx ? side_q[W].bsx - $signed(qx_q[W])
                                   : side_q[W].bsx + $signed(qx_q[W]);
      res_o.point_y = side_q[W].sy ? side_q[W].bsy - $signed(qy_q[W])
                                   : side_q[W].bsy + $signed(qy_q[W]);
    end else begin
      res_o.point_x = side_q[W].aex;
      res_o.point_y = side_q[W].aey;
    end
  end

  assign valid_o = v_q[W];

endmodule

`default_nettype wire

FILE: hdl/segment_intersection_point.sv
// Throughput: one pair per cycle when no half stalls; the back end spends one restoring-divider
// stage per quotient bit, pipelined, so all of its stages work on different pairs at once.
// Stalls: each half holds only while its last stage has a result and its queue is full.
// Reset: asynchronous, active low; clears pipeline valid bits and queue pointers.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_point #(
  parameter int MID_DEPTH = sip_pkg::MidDepth,
  parameter int OUT_DEPTH = sip_pkg::OutDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire sip_pkg::seg_t seg_i,
  output logic               empty,
  input  wire logic          pop,
  output sip_pkg::res_t      res_o
);

  localparam int JobW = $bits(sip_pkg::job_t);
  localparam int ResW = $bits(sip_pkg::res_t);

  logic          front_en, front_valid;
  sip_pkg::job_t front_job, mid_job;
  logic [JobW-1:0] mid_rdata;
  logic          mid_push, mid_pop, mid_full, mid_empty;

  logic          back_en, back_valid;
  sip_pkg::res_t back_res;
  logic [ResW-1:0] out_rdata;
  logic          out_push, out_pop, out_full, out_empty;

  assign front_en = !(front_valid && mid_full);
  assign mid_push = front_valid && !mid_full;
  assign back_en  = !(back_valid && out_full);
  assign mid_pop  = back_en && !mid_empty;
  assign out_push = back_valid && !out_full;
  assign out_pop  = pop && !out_empty;

  assign full    = !front_en;
  assign empty   = out_empty;
  assign mid_job = mid_rdata;
  assign res_o   = out_rdata;

  sip_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (front_en),
    .valid_i (push),
    .seg_i   (seg_i),
    .valid_o (front_valid),
    .job_o   (front_job)
  );

  sip_fifo #(
    .WIDTH (JobW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (front_job),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  sip_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (back_en),
    .valid_i (!mid_empty),
    .job_i   (mid_job),
    .valid_o (back_valid),
    .res_o   (back_res)
  );

  sip_fifo #(
    .WIDTH (ResW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (back_res),
    .pop_i   (out_pop),
    .rdata_o (out_rdata),
    .full_o  (out_full),
    .empty_o (out_empty)
  );

endmodule

`default_nettype wire
